FILE: rtl/gm_pkg.sv
// ----------------------------------------------------------------------------
// gm_pkg: shared constants for the gradient magnitude block
// Default geometry, register map codes and the magnitude clamp value.
// ----------------------------------------------------------------------------
package gm_pkg;

	localparam int DEF_MAX_WIDTH  = 2048;
	localparam int DEF_MAX_HEIGHT = 2048;
	localparam int DEF_COEFF_BITS = 4;
	localparam int DEF_PIXEL_BITS = 8;
	localparam int DEF_Q_DEPTH    = 4;

	localparam int RST_WIDTH  = 640;
	localparam int RST_HEIGHT = 480;
	localparam int MIN_DIM    = 3;

	localparam int TAPS     = 9;
	localparam int MAG_BITS = 8;
	localparam int MAG_MAX  = 255;

	localparam int ADDR_BITS = 5;
	localparam int DATA_BITS = 64;

	typedef enum logic [1:0] {
		REG_WIDTH  = 2'd0,
		REG_HEIGHT = 2'd1,
		REG_KX     = 2'd2,
		REG_KY     = 2'd3
	} reg_idx_t;

	typedef struct packed {
		logic empty;
		logic pop;
	} q_ctl_t;

endpackage

FILE: rtl/gm_queue.sv
// ----------------------------------------------------------------------------
// gm_queue: short window queue
// Decouples the window builder from the magnitude unit.
// ----------------------------------------------------------------------------
module gm_queue #(
	parameter int WIDTH = 73,
	parameter int DEPTH = gm_pkg::DEF_Q_DEPTH
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       wr_en,
	input  logic [WIDTH-1:0]           wr_data,
	input  gm_pkg::q_ctl_t             ctl_in,
	output logic                       q_empty,
	output logic [WIDTH-1:0]           rd_data,
	output logic [$clog2(DEPTH+1)-1:0] count
);
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [AW-1:0]    wr_ptr_q, rd_ptr_q;
	logic [CW-1:0]    cnt_q;
	logic             rd_en;

	assign rd_en   = ctl_in.pop & ~ctl_in.empty;
	assign q_empty = (cnt_q == '0);
	assign rd_data = mem_q[rd_ptr_q];
	assign count   = cnt_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (wr_en) begin
				wr_ptr_q <= (wr_ptr_q == AW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (rd_en) begin
				rd_ptr_q <= (rd_ptr_q == AW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (wr_en && !rd_en) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (!wr_en && rd_en) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

`ifndef SYNTHESIS
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		(cnt_q == CW'(DEPTH)) |-> !wr_en || rd_en) else $error("queue overflow");
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		(ctl_in.empty == q_empty)) else $error("queue empty flag mismatch");
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CW'(DEPTH)) else $error("queue count out of range");
`endif

endmodule

FILE: rtl/gm_front.sv
// ----------------------------------------------------------------------------
// gm_front: line stores, window and raster counters
// Accepts pixels, builds 3x3 windows and queues interior windows.
// ----------------------------------------------------------------------------
module gm_front #(
	parameter int MAX_WIDTH  = gm_pkg::DEF_MAX_WIDTH,
	parameter int MAX_HEIGHT = gm_pkg::DEF_MAX_HEIGHT,
	parameter int PIXEL_BITS = gm_pkg::DEF_PIXEL_BITS,
	parameter int Q_DEPTH    = gm_pkg::DEF_Q_DEPTH
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  push,
	input  logic [PIXEL_BITS-1:0]                 pixel,
	output logic                                  full,
	input  logic [$clog2(MAX_WIDTH+1)-1:0]        img_w,
	input  logic [$clog2(MAX_HEIGHT+1)-1:0]       img_h,
	input  logic [$clog2(Q_DEPTH+1)-1:0]          q_count,
	output logic                                  q_wr,
	output logic [gm_pkg::TAPS*PIXEL_BITS:0]      q_wdata
);
	localparam int CW  = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
	localparam int RW  = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
	localparam int WW  = $clog2(MAX_WIDTH + 1);
	localparam int HW  = $clog2(MAX_HEIGHT + 1);
	localparam int QCW = $clog2(Q_DEPTH + 1);
	localparam int PB  = PIXEL_BITS;

	logic [PB-1:0] up_mem [MAX_WIDTH];
	logic [PB-1:0] mid_mem [MAX_WIDTH];

	logic [CW-1:0] col_q, clr_q;
	logic [RW-1:0] row_q;
	logic          clr_busy_q;
	logic          acc, last_col, last_row;

	logic          v_s1, prod_s1, last_s1;
	logic [CW-1:0] c_s1;
	logic [PB-1:0] px_s1, up_s1, mid_s1;

	logic [PB-1:0] win_q [gm_pkg::TAPS];
	logic [PB-1:0] win_d [gm_pkg::TAPS];

	assign acc      = push & ~full;
	assign last_col = ((WW+1)'(col_q) + 1'b1) >= (WW+1)'(img_w);
	assign last_row = ((HW+1)'(row_q) + 1'b1) >= (HW+1)'(img_h);
	assign full     = clr_busy_q | (((QCW+1)'(q_count) + (QCW+1)'(v_s1)) >= (QCW+1)'(Q_DEPTH));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q      <= '0;
			row_q      <= '0;
			clr_q      <= '0;
			clr_busy_q <= 1'b1;
			v_s1       <= 1'b0;
		end else begin
			v_s1 <= acc;
			if (clr_busy_q) begin
				clr_q <= clr_q + 1'b1;
				if (clr_q == CW'(MAX_WIDTH - 1)) begin
					clr_busy_q <= 1'b0;
				end
			end
			if (acc) begin
				if (last_col) begin
					col_q <= '0;
					row_q <= last_row ? '0 : row_q + 1'b1;
				end else begin
					col_q <= col_q + 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			up_s1   <= up_mem[col_q];
			mid_s1  <= mid_mem[col_q];
			px_s1   <= pixel;
			c_s1    <= col_q;
			prod_s1 <= (col_q >= CW'(2)) && (row_q >= RW'(2));
			last_s1 <= last_col & last_row;
		end
		if (clr_busy_q) begin
			up_mem[clr_q]  <= '0;
			mid_mem[clr_q] <= '0;
		end else if (v_s1) begin
			up_mem[c_s1]  <= mid_s1;
			mid_mem[c_s1] <= px_s1;
		end
	end

	always_comb begin
		win_d[0] = win_q[1];
		win_d[1] = win_q[2];
		win_d[2] = up_s1;
		win_d[3] = win_q[4];
		win_d[4] = win_q[5];
		win_d[5] = mid_s1;
		win_d[6] = win_q[7];
		win_d[7] = win_q[8];
		win_d[8] = px_s1;
	end

	always_ff @(posedge clk) begin
		if (v_s1) begin
			win_q <= win_d;
		end
	end

	assign q_wr = v_s1 & prod_s1;

	always_comb begin
		q_wdata = '0;
		for (int i = 0; i < gm_pkg::TAPS; i++) begin
			q_wdata[i*PB +: PB] = win_d[i];
		end
		q_wdata[gm_pkg::TAPS*PB] = last_s1;
	end

endmodule

FILE: rtl/gm_back.sv
// ----------------------------------------------------------------------------
// gm_back: gradient magnitude unit
// Convolves with both kernels, squares, takes a bit-serial root or clamps.
// ----------------------------------------------------------------------------
module gm_back #(
	parameter int PIXEL_BITS = gm_pkg::DEF_PIXEL_BITS,
	parameter int COEFF_BITS = gm_pkg::DEF_COEFF_BITS,
	parameter int KW         = 36
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                q_empty,
	input  logic [gm_pkg::TAPS*PIXEL_BITS:0]    q_rdata,
	output gm_pkg::q_ctl_t                      q_ctl,
	input  logic [KW-1:0]                       kx,
	input  logic [KW-1:0]                       ky,
	input  logic                                pop,
	output logic                                empty,
	output logic [gm_pkg::MAG_BITS-1:0]         magnitude,
	output logic                                frame_last
);
	localparam int PB = PIXEL_BITS;
	localparam int CB = COEFF_BITS;
	localparam int PW = PB + CB + 1;
	localparam int G  = PW + 4;
	localparam int SQ = 2 * G;
	localparam int MB = gm_pkg::MAG_BITS;

	typedef enum logic [2:0] {S_IDLE, S_SUM, S_SQ, S_ADD, S_ROOT, S_OUT} state_t;

	state_t                   state_q;
	logic [PB-1:0]            win_q [gm_pkg::TAPS];
	logic                     last_q;
	logic signed [G-1:0]      gx_q, gy_q, gx_d, gy_d;
	logic [G-1:0]             ax, ay;
	logic [SQ-1:0]            sqx_q, sqy_q;
	logic [SQ:0]              sum_q;
	logic [MB-1:0]            root_q, bit_q, trial;
	logic                     out_v_q;
	logic                     ld_out;
	logic signed [CB-1:0]     tx [gm_pkg::TAPS];
	logic signed [CB-1:0]     ty [gm_pkg::TAPS];

	for (genvar i = 0; i < gm_pkg::TAPS; i++) begin : g_tap
		if ((i + 1) * CB <= KW) begin : g_in
			assign tx[i] = kx[i*CB +: CB];
			assign ty[i] = ky[i*CB +: CB];
		end else begin : g_out
			assign tx[i] = '0;
			assign ty[i] = '0;
		end
	end

	always_comb begin
		gx_d = '0;
		gy_d = '0;
		for (int i = 0; i < gm_pkg::TAPS; i++) begin
			gx_d = gx_d + G'(signed'({1'b0, win_q[i]}) * tx[i]);
			gy_d = gy_d + G'(signed'({1'b0, win_q[i]}) * ty[i]);
		end
	end

	assign ax    = gx_q[G-1] ? G'(-gx_q) : G'(gx_q);
	assign ay    = gy_q[G-1] ? G'(-gy_q) : G'(gy_q);
	assign trial = root_q | bit_q;

	assign q_ctl.empty = q_empty;
	assign q_ctl.pop   = (state_q == S_IDLE);
	assign empty       = ~out_v_q;
	assign ld_out      = (state_q == S_OUT) && (!out_v_q || pop);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			out_v_q <= 1'b0;
		end else begin
			if (ld_out) begin
				out_v_q <= 1'b1;
			end else if (pop && out_v_q) begin
				out_v_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (!q_empty) begin
						state_q <= S_SUM;
					end
				end
				S_SUM:  state_q <= S_SQ;
				S_SQ:   state_q <= S_ADD;
				S_ADD:  state_q <= (((SQ+1)'(sqx_q) + (SQ+1)'(sqy_q)) >=
					(SQ+1)'(gm_pkg::MAG_MAX * gm_pkg::MAG_MAX)) ? S_OUT : S_ROOT;
				S_ROOT: begin
					if (bit_q[0]) begin
						state_q <= S_OUT;
					end
				end
				S_OUT: begin
					if (ld_out) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				for (int i = 0; i < gm_pkg::TAPS; i++) begin
					win_q[i] <= q_rdata[i*PB +: PB];
				end
				last_q <= q_rdata[gm_pkg::TAPS*PB];
			end
			S_SUM: begin
				gx_q <= gx_d;
				gy_q <= gy_d;
			end
			S_SQ: begin
				sqx_q <= ax * ax;
				sqy_q <= ay * ay;
			end
			S_ADD: begin
				sum_q  <= (SQ+1)'(sqx_q) + (SQ+1)'(sqy_q);
				root_q <= '0;
				bit_q  <= {1'b1, {(MB-1){1'b0}}};
			end
			S_ROOT: begin
				if ((SQ+1)'(trial * trial) <= sum_q) begin
					root_q <= trial;
				end
				bit_q <= bit_q >> 1;
			end
			S_OUT: begin
				if (!out_v_q || pop) begin
					magnitude  <= (sum_q >= (SQ+1)'(gm_pkg::MAG_MAX * gm_pkg::MAG_MAX)) ?
						MB'(gm_pkg::MAG_MAX) : root_q;
					frame_last <= last_q;
				end
			end
			default: ;
		endcase
	end

`ifndef SYNTHESIS
	a_bit_onehot: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_ROOT) |-> $onehot(bit_q)) else $error("root bit not one-hot");
	a_root_ends: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_ROOT && bit_q[0]) |=> (state_q == S_OUT)) else $error("root overrun");
	a_load: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_IDLE && !q_empty) |=> (state_q == S_SUM)) else $error("load missed");
`endif

endmodule

FILE: rtl/gradient_magnitude_3x3.sv
// ----------------------------------------------------------------------------
// gradient_magnitude_3x3: two-kernel 3x3 gradient magnitude on a pixel stream
// Pixels enter in raster order; one magnitude leaves per interior pixel.
//
// Input queue side: drive pixel with push; a transfer happens when full is low.
// Output queue side: magnitude and frame_last are valid while empty is low; a
// transfer happens when pop is high. frame_last marks the last interior result.
// Configuration: APB registers at 0x00 width, 0x08 height, 0x10 and 0x18 kernels.
// A window's result passes the stage-one registers, the window queue and the
// load, sum, square, add, bit-serial root and output states of the magnitude
// unit. Pixels that give no result are taken back to back while full is low;
// the magnitude unit works on one window at a time, and a four-entry window
// queue soaks up border pixels. After reset the line stores are cleared, one
// column a cycle; full stays high meanwhile. If the receiver stalls, the
// result holds, the queue fills and full rises.
// ----------------------------------------------------------------------------
module gradient_magnitude_3x3 #(
	parameter int MAX_WIDTH  = gm_pkg::DEF_MAX_WIDTH,
	parameter int MAX_HEIGHT = gm_pkg::DEF_MAX_HEIGHT,
	parameter int COEFF_BITS = gm_pkg::DEF_COEFF_BITS,
	parameter int PIXEL_BITS = gm_pkg::DEF_PIXEL_BITS
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              push,
	input  logic [PIXEL_BITS-1:0]             pixel,
	output logic                              full,
	input  logic                              pop,
	output logic                              empty,
	output logic [gm_pkg::MAG_BITS-1:0]       magnitude,
	output logic                              frame_last,
	input  logic                              psel,
	input  logic                              penable,
	input  logic                              pwrite,
	input  logic [gm_pkg::ADDR_BITS-1:0]      paddr,
	input  logic [gm_pkg::DATA_BITS-1:0]      pwdata,
	output logic [gm_pkg::DATA_BITS-1:0]      prdata,
	output logic                              pready
);
	localparam int WW  = $clog2(MAX_WIDTH + 1);
	localparam int HW  = $clog2(MAX_HEIGHT + 1);
	localparam int KW  = (gm_pkg::TAPS * COEFF_BITS > gm_pkg::DATA_BITS) ?
		gm_pkg::DATA_BITS : gm_pkg::TAPS * COEFF_BITS;
	localparam int QD  = gm_pkg::DEF_Q_DEPTH;
	localparam int QW  = gm_pkg::TAPS * PIXEL_BITS + 1;
	localparam int RSW = (gm_pkg::RST_WIDTH > MAX_WIDTH) ? MAX_WIDTH : gm_pkg::RST_WIDTH;
	localparam int RSH = (gm_pkg::RST_HEIGHT > MAX_HEIGHT) ? MAX_HEIGHT : gm_pkg::RST_HEIGHT;

	logic [WW-1:0]             img_w_q;
	logic [HW-1:0]             img_h_q;
	logic [KW-1:0]             kx_q, ky_q;
	logic                      wr;
	gm_pkg::reg_idx_t          idx;
	logic                      q_wr;
	logic [QW-1:0]             q_wdata, q_rdata;
	logic                      q_empty;
	logic [$clog2(QD+1)-1:0]   q_count;
	gm_pkg::q_ctl_t            q_ctl;

	assign pready = 1'b1;
	assign wr     = psel & penable & pwrite;
	assign idx    = gm_pkg::reg_idx_t'(paddr[4:3]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			img_w_q <= WW'(RSW);
			img_h_q <= HW'(RSH);
			kx_q    <= '0;
			ky_q    <= '0;
		end else if (wr) begin
			case (idx)
				gm_pkg::REG_WIDTH: begin
					if (pwdata < 64'(gm_pkg::MIN_DIM)) begin
						img_w_q <= WW'(gm_pkg::MIN_DIM);
					end else if (pwdata > 64'(MAX_WIDTH)) begin
						img_w_q <= WW'(MAX_WIDTH);
					end else begin
						img_w_q <= pwdata[WW-1:0];
					end
				end
				gm_pkg::REG_HEIGHT: begin
					if (pwdata < 64'(gm_pkg::MIN_DIM)) begin
						img_h_q <= HW'(gm_pkg::MIN_DIM);
					end else if (pwdata > 64'(MAX_HEIGHT)) begin
						img_h_q <= HW'(MAX_HEIGHT);
					end else begin
						img_h_q <= pwdata[HW-1:0];
					end
				end
				gm_pkg::REG_KX: kx_q <= pwdata[KW-1:0];
				gm_pkg::REG_KY: ky_q <= pwdata[KW-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (idx)
			gm_pkg::REG_WIDTH:  prdata = 64'(img_w_q);
			gm_pkg::REG_HEIGHT: prdata = 64'(img_h_q);
			gm_pkg::REG_KX:     prdata = 64'(kx_q);
			gm_pkg::REG_KY:     prdata = 64'(ky_q);
			default:            prdata = '0;
		endcase
	end

	gm_front #(
		.MAX_WIDTH  (MAX_WIDTH),
		.MAX_HEIGHT (MAX_HEIGHT),
		.PIXEL_BITS (PIXEL_BITS),
		.Q_DEPTH    (QD)
	) u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.pixel   (pixel),
		.full    (full),
		.img_w   (img_w_q),
		.img_h   (img_h_q),
		.q_count (q_count),
		.q_wr    (q_wr),
		.q_wdata (q_wdata)
	);

	gm_queue #(
		.WIDTH (QW),
		.DEPTH (QD)
	) u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (q_wr),
		.wr_data (q_wdata),
		.ctl_in  (q_ctl),
		.q_empty (q_empty),
		.rd_data (q_rdata),
		.count   (q_count)
	);

	gm_back #(
		.PIXEL_BITS (PIXEL_BITS),
		.COEFF_BITS (COEFF_BITS),
		.KW         (KW)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.q_empty    (q_empty),
		.q_rdata    (q_rdata),
		.q_ctl      (q_ctl),
		.kx         (kx_q),
		.ky         (ky_q),
		.pop        (pop),
		.empty      (empty),
		.magnitude  (magnitude),
		.frame_last (frame_last)
	);

endmodule

FILE: tb/sv/gradient_magnitude_3x3_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// gradient_magnitude_3x3_test: self-checking bench for the gradient magnitude
// A queue of pixels feeds a clocked driver; a clocked monitor checks every
// magnitude and frame flag against a predictor of the window, line stores and
// kernels. Geometry and kernels change between phases while the block is idle.
// ----------------------------------------------------------------------------
module gradient_magnitude_3x3_test;

	localparam int MAXW = gm_pkg::DEF_MAX_WIDTH;
	localparam int MAXH = gm_pkg::DEF_MAX_HEIGHT;
	localparam int WATCHDOG = 20000;
	localparam logic [35:0] SOBEL_X = 36'h10F20E10F;
	localparam logic [35:0] SOBEL_Y = 36'h121000FEF;

	typedef struct {
		logic [gm_pkg::MAG_BITS-1:0] mag;
		logic                        last;
	} grad_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic push = 1'b0;
	logic [gm_pkg::DEF_PIXEL_BITS-1:0] pixel = '0;
	logic full;
	logic pop = 1'b0;
	logic empty;
	logic [gm_pkg::MAG_BITS-1:0] magnitude;
	logic frame_last;
	logic psel = 1'b0;
	logic penable = 1'b0;
	logic pwrite = 1'b0;
	logic [gm_pkg::ADDR_BITS-1:0] paddr = '0;
	logic [gm_pkg::DATA_BITS-1:0] pwdata = '0;
	logic [gm_pkg::DATA_BITS-1:0] prdata;
	logic pready;

	gradient_magnitude_3x3 dut (.*);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// predictor state
	logic [7:0]  row_up [MAXW];
	logic [7:0]  row_mid [MAXW];
	logic [7:0]  win [9];
	int unsigned col_pos, row_pos;
	int unsigned img_w = gm_pkg::RST_WIDTH, img_h = gm_pkg::RST_HEIGHT;
	logic [63:0] kern_x = '0, kern_y = '0;

	logic [7:0] pixels_pending [$];
	grad_t      grads_due [$];
	int unsigned send_idle_pct = 0, recv_stall_pct = 0;
	int errors = 0;
	int quiet_cycles = 0;
	bit taken = 1'b0;

	function automatic int signed tap(logic [63:0] k, int i);
		logic signed [3:0] t;
		t = k[4*i +: 4];
		return t;
	endfunction

	function automatic void predict_pixel(logic [7:0] px);
		int unsigned c, r;
		longint signed gx, gy;
		longint unsigned s;
		int unsigned root;
		grad_t g;
		c = col_pos % MAXW;
		r = row_pos;
		win[0] = win[1]; win[1] = win[2]; win[2] = row_up[c];
		win[3] = win[4]; win[4] = win[5]; win[5] = row_mid[c];
		win[6] = win[7]; win[7] = win[8]; win[8] = px;
		row_up[c] = row_mid[c];
		row_mid[c] = px;
		if (c >= 2 && r >= 2) begin
			gx = 0;
			gy = 0;
			for (int i = 0; i < gm_pkg::TAPS; i++) begin
				gx += longint'(win[i]) * tap(kern_x, i);
				gy += longint'(win[i]) * tap(kern_y, i);
			end
			s = gx * gx + gy * gy;
			root = 0;
			if (s >= gm_pkg::MAG_MAX * gm_pkg::MAG_MAX) begin
				root = gm_pkg::MAG_MAX;
			end else begin
				for (int b = 128; b != 0; b >>= 1)
					if ((root | b) * (root | b) <= s) root |= b;
			end
			g.mag = root[7:0];
			g.last = (c + 1 >= img_w) && (r + 1 >= img_h);
			grads_due.push_back(g);
		end
		if (c + 1 >= img_w) begin
			col_pos = 0;
			row_pos = (r + 1 >= img_h) ? 0 : r + 1;
		end else begin
			col_pos = c + 1;
		end
	endfunction

	function automatic int unsigned clamp_dim(logic [63:0] v, int unsigned m);
		if (v < gm_pkg::MIN_DIM) return gm_pkg::MIN_DIM;
		if (v > m) return m;
		return v[31:0];
	endfunction

	always @(posedge clk) begin
		grad_t g;
		if (push && !full) begin
			predict_pixel(pixel);
			taken = 1'b1;
			quiet_cycles = 0;
		end
		if (pop && !empty) begin
			quiet_cycles = 0;
			if (grads_due.size() == 0) begin
				$error("magnitude transfer with nothing expected: %0d", magnitude);
				errors++;
			end else begin
				g = grads_due.pop_front();
				if (magnitude !== g.mag) begin
					$error("magnitude: expected %0d, got %0d", g.mag, magnitude);
					errors++;
				end
				if (frame_last !== g.last) begin
					$error("frame_last: expected %0d, got %0d", g.last, frame_last);
					errors++;
				end
			end
		end
		if (arst_n && ++quiet_cycles >= WATCHDOG) begin
			$display("TB_ERROR");
			$finish;
		end
	end

	always @(negedge clk) begin
		if (taken || !push) begin
			if (pixels_pending.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
				push <= 1'b1;
				pixel <= pixels_pending.pop_front();
			end else begin
				push <= 1'b0;
			end
		end
		taken = 1'b0;
		pop <= arst_n && ($urandom_range(99) >= recv_stall_pct);
	end

	task automatic write_reg(gm_pkg::reg_idx_t idx, logic [63:0] val);
		@(negedge clk);
		psel <= 1'b1;
		pwrite <= 1'b1;
		paddr <= gm_pkg::ADDR_BITS'(int'(idx) * 8);
		pwdata <= val;
		@(negedge clk);
		penable <= 1'b1;
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		case (idx)
			gm_pkg::REG_WIDTH:  img_w = clamp_dim(val, MAXW);
			gm_pkg::REG_HEIGHT: img_h = clamp_dim(val, MAXH);
			gm_pkg::REG_KX:     kern_x = val;
			gm_pkg::REG_KY:     kern_y = val;
			default: ;
		endcase
	endtask

	task automatic drain();
		while (pixels_pending.size() != 0 || push || grads_due.size() != 0)
			@(posedge clk);
		repeat (30) @(posedge clk);
	endtask

	task automatic set_mode(int m);
		send_idle_pct = (m == 1) ? 78 : (m == 3) ? 25 : 0;
		recv_stall_pct = (m == 2) ? 78 : (m == 3) ? 25 : 0;
	endtask

	initial begin
		int sent, ph, w, h, n, pick;
		foreach (row_up[i]) begin
			row_up[i] = '0;
			row_mid[i] = '0;
		end
		foreach (win[i]) win[i] = '0;
		col_pos = 0;
		row_pos = 0;
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		write_reg(gm_pkg::REG_WIDTH, 64'd0);
		write_reg(gm_pkg::REG_HEIGHT, 64'd2);
		write_reg(gm_pkg::REG_KX, 64'h888888888);
		write_reg(gm_pkg::REG_KY, 64'h777777777);
		repeat (9) pixels_pending.push_back(8'd255);
		drain();
		write_reg(gm_pkg::REG_KX, 64'(SOBEL_X));
		write_reg(gm_pkg::REG_KY, 64'(SOBEL_Y));
		for (int i = 0; i < 9; i++) pixels_pending.push_back(i[0] ? 8'd255 : 8'd0);
		drain();

		sent = 0;
		ph = 0;
		while (sent < 1000) begin
			set_mode(ph % 4);
			pick = $urandom_range(9);
			w = (pick == 0) ? $urandom_range(2) : $urandom_range(3, 12);
			h = $urandom_range(3, 6);
			write_reg(gm_pkg::REG_WIDTH, 64'(w));
			write_reg(gm_pkg::REG_HEIGHT, 64'(h));
			if (pick < 5) begin
				write_reg(gm_pkg::REG_KX, {28'd0, $urandom(), 4'($urandom())});
				write_reg(gm_pkg::REG_KY, {28'd0, $urandom(), 4'($urandom())});
			end else if (pick < 8) begin
				write_reg(gm_pkg::REG_KX, 64'(SOBEL_X));
				write_reg(gm_pkg::REG_KY, 64'(SOBEL_Y));
			end
			n = img_w * img_h * $urandom_range(1, 3);
			if ($urandom_range(3) == 0) n += $urandom_range(1, 2 * img_w);
			for (int i = 0; i < n; i++)
				pixels_pending.push_back($urandom_range(7) == 0 ?
					($urandom_range(1) ? 8'd255 : 8'd0) : 8'($urandom()));
			sent += n;
			drain();
			ph++;
		end

		set_mode(3);
		write_reg(gm_pkg::REG_WIDTH, 64'hFFF);
		write_reg(gm_pkg::REG_HEIGHT, 64'd3);
		for (int i = 0; i < 200; i++) pixels_pending.push_back(8'($urandom()));
		drain();
		set_mode(0);
		write_reg(gm_pkg::REG_WIDTH, 64'd3);
		write_reg(gm_pkg::REG_HEIGHT, 64'hFFF);
		for (int i = 0; i < 150; i++) pixels_pending.push_back(8'($urandom()));
		drain();

		if (errors == 0) begin
			$display("TB_OK");
		end else begin
			$display("TB_ERROR");
		end
		$finish;
	end

endmodule

FILE: files.f
rtl/gm_pkg.sv
rtl/gm_queue.sv
rtl/gm_front.sv
rtl/gm_back.sv
rtl/gradient_magnitude_3x3.sv
tb/sv/gradient_magnitude_3x3_test.sv
